/* rtl/core/averaged_divider_resistance_macros.svh */
// Assertion helpers for the divider resistance meter.
// Each check is sampled on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef AVERAGED_DIVIDER_RESISTANCE_MACROS_SVH
`define AVERAGED_DIVIDER_RESISTANCE_MACROS_SVH

`ifndef SYNTHESIS
`define ADR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ADR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ADR_ASSERT_IMP(name, ante, cons, msg)
`define ADR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/core/adr_pkg.sv */
package adr_pkg;

    localparam int ADC_BITS   = 10;
    localparam int SAMPLE_W   = 10;
    localparam int CNT_W      = 10;
    localparam int SUM_W      = ADC_BITS + CNT_W;
    localparam int AVG_FRAC   = 6;
    localparam int AVG_W      = 16;
    localparam int MV_W       = 13;
    localparam int R_W        = 20;
    localparam int OHMS_W     = 32;
    localparam int NUM_W      = R_W + SUM_W;
    localparam int STEP_W     = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = R_W;

    // Iterations of the shared divider for each quotient.
    localparam int AVG_ITERS = AVG_FRAC + SUM_W;
    localparam int MV_ITERS  = MV_W + SUM_W;
    localparam int OHM_ITERS = NUM_W;

    localparam int S_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = AVG_W + MV_W + OHMS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int AVG_SCALE = 1 << AVG_FRAC;
    localparam logic [SUM_W-1:0]    FULL_CODE   = SUM_W'((1 << ADC_BITS) - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);
    localparam logic [AVG_W-1:0]    AVG_MAX     = AVG_W'(((1 << ADC_BITS) - 1) * AVG_SCALE);

    localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = CNT_W'(50);
    localparam logic             RST_PULL_UP      = 1'b0;
    localparam logic [MV_W-1:0]  RST_REF_MV       = MV_W'(3300);
    localparam logic [R_W-1:0]   RST_KNOWN_OHMS   = R_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_PULL_UP      = 2'd1,
        CFG_REF_MV       = 2'd2,
        CFG_KNOWN_OHMS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_AVG,
        OP_MV,
        OP_OHM
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0] sample_count;
        logic             pull_up_mode;
        logic [MV_W-1:0]  ref_millivolts;
        logic [R_W-1:0]   known_ohms;
    } t_cfg;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic mul;
        logic div_load;
        logic div_step;
        logic store;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic out_free;
    } t_dp_sts;

    function automatic logic [STEP_W-1:0] op_iters(input t_op op);
        logic [STEP_W-1:0] iters;
        case (op)
            OP_AVG:  iters = STEP_W'(AVG_ITERS);
            OP_MV:   iters = STEP_W'(MV_ITERS);
            default: iters = STEP_W'(OHM_ITERS);
        endcase
        return iters;
    endfunction

endpackage

/* rtl/core/adr_ctrl.sv */
module adr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  adr_pkg::t_dp_sts i_sts,
    output adr_pkg::t_dp_cmd o_cmd
);
    import adr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_ready;
    logic              w_accept;

    assign w_accept   = i_s_tvalid && r_ready;
    assign o_s_tready = r_ready;

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_steps        = r_steps;
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.accept   = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_sts.close) begin
                    n_op    = OP_AVG;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_steps        = op_iters(r_op);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_steps        = r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                case (r_op)
                    OP_AVG: begin
                        n_op    = OP_MV;
                        n_state = S_MUL;
                    end
                    OP_MV: begin
                        n_op    = OP_OHM;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                // The previous result must have left the output register first.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_AVG;
            r_steps <= '0;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_steps <= n_steps;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

/* rtl/core/adr_dpath.sv */
module adr_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  adr_pkg::t_cfg                i_cfg,
    input  adr_pkg::t_dp_cmd             i_cmd,
    output adr_pkg::t_dp_sts             o_sts,
    input  logic [adr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [adr_pkg::AVG_W-1:0]    o_average_q6,
    output logic [adr_pkg::MV_W-1:0]     o_millivolts,
    output logic [adr_pkg::OHMS_W-1:0]   o_ohms,
    output logic                         o_saturated
);
    import adr_pkg::*;

    // Accumulator.
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] w_sum_inc;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [CNT_W-1:0] w_limit;
    logic             w_close;

    // Closed window.
    logic [SUM_W-1:0] r_win_sum;
    logic [CNT_W-1:0] r_win_n;
    logic [SUM_W-1:0] w_full;
    logic [SUM_W-1:0] w_gap;

    // Multiplier and shared restoring divider.
    logic [R_W-1:0]   w_mul_a;
    logic [SUM_W-1:0] w_mul_b;
    logic [SUM_W-1:0] w_den;
    logic [NUM_W-1:0] r_prod;
    logic [NUM_W-1:0] r_num;
    logic [SUM_W-1:0] r_den;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W:0]   w_rem_sh;
    logic [SUM_W:0]   w_rem_sub;
    logic             w_ge;

    // Quotients and output register.
    logic [AVG_W-1:0]  r_avg;
    logic [MV_W-1:0]   r_mv;
    logic [OHMS_W-1:0] r_ohms;
    logic              r_sat;
    logic              r_m_valid;
    logic [AVG_W-1:0]  r_o_avg;
    logic [MV_W-1:0]   r_o_mv;
    logic [OHMS_W-1:0] r_o_ohms;
    logic              r_o_sat;

    assign w_sum_inc = r_sum + SUM_W'(i_sample & SAMPLE_MASK);
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_limit   = (i_cfg.sample_count == '0) ? CNT_W'(1) : i_cfg.sample_count;
    // A count lowered in mid-window closes the window on the next sample.
    assign w_close   = (w_cnt_inc >= w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            if (w_close) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= w_sum_inc;
                r_cnt <= w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_close) begin
            r_win_sum <= w_sum_inc;
            r_win_n   <= w_cnt_inc;
        end
    end

    assign w_full = SUM_W'(r_win_n) * FULL_CODE;
    assign w_gap  = w_full - r_win_sum;

    always_comb begin
        case (i_cmd.op)
            OP_MV: begin
                w_mul_a = R_W'(i_cfg.ref_millivolts);
                w_mul_b = r_win_sum;
                w_den   = w_full;
            end
            OP_OHM: begin
                w_mul_a = i_cfg.known_ohms;
                w_mul_b = i_cfg.pull_up_mode ? w_gap : r_win_sum;
                w_den   = i_cfg.pull_up_mode ? r_win_sum : w_gap;
            end
            default: begin
                w_mul_a = R_W'(AVG_SCALE);
                w_mul_b = r_win_sum;
                w_den   = SUM_W'(r_win_n);
            end
        endcase
    end

    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= NUM_W'(w_mul_a) * NUM_W'(w_mul_b);
        end
        if (i_cmd.div_load) begin
            // Left-align the dividend so that the quotient ends in the low bits.
            r_den <= w_den;
            r_rem <= '0;
            case (i_cmd.op)
                OP_AVG:  r_num <= r_prod << (NUM_W - AVG_ITERS);
                OP_MV:   r_num <= r_prod << (NUM_W - MV_ITERS);
                default: r_num <= r_prod << (NUM_W - OHM_ITERS);
            endcase
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[SUM_W-1:0] : w_rem_sh[SUM_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_cmd.op)
                OP_AVG: begin
                    r_avg <= r_num[AVG_W-1:0];
                end
                OP_MV: begin
                    r_mv <= r_num[MV_W-1:0];
                end
                default: begin
                    if ((r_den == '0) || (r_num[NUM_W-1:OHMS_W] != '0)) begin
                        r_ohms <= '1;
                        r_sat  <= 1'b1;
                    end else begin
                        r_ohms <= r_num[OHMS_W-1:0];
                        r_sat  <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_avg  <= r_avg;
            r_o_mv   <= r_mv;
            r_o_ohms <= r_ohms;
            r_o_sat  <= r_sat;
        end
    end

    assign o_sts.close    = w_close;
    assign o_sts.out_free = !r_m_valid || i_m_tready;

    assign o_m_tvalid   = r_m_valid;
    assign o_average_q6 = r_o_avg;
    assign o_millivolts = r_o_mv;
    assign o_ohms       = r_o_ohms;
    assign o_saturated  = r_o_sat;

endmodule

/* rtl/core/averaged_divider_resistance.sv */
// Averaged voltage-divider resistance meter.
// Slave stream s_axis carries one ADC code per request in tdata. Every sample_count
// samples close a window, and the master stream m_axis then carries one result:
// the average in 10.6 fixed point, the voltage in millivolts and the sensor
// resistance in ohms, with tuser flagging a saturated resistance.
// A sample that does not close a window leaves s_axis_tready high, so the next can
// follow at once. A closing sample starts three quotients on one shared restoring
// divider, one bit per cycle: 26, 33 and 40 iterations, each with a multiply, a load
// and a store step, and a final step loads the output register. s_axis_tready stays
// low from the closing request until the output register is loaded.
// The result sits in an output register; while the receiver stalls, samples are
// still accepted, and only the next closed window waits for that register.
// Registers must be written by the user through i_cfg_we/i_cfg_idx/i_cfg_wdata only
// while idle; the block does not enforce it. Synchronous reset clears the sum, the
// sample count and any pending result, and loads sample_count 50, pull-down mode,
// 3300 mV and 10000 ohms.
module averaged_divider_resistance (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [adr_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [adr_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // average_q6, millivolts, ohms
    output logic [0:0]                     m_axis_tuser,  // saturated
    input  logic                           i_cfg_we,
    input  logic [adr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [adr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import adr_pkg::*;

`include "averaged_divider_resistance_macros.svh"

    t_cfg              r_cfg;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [AVG_W-1:0]  w_avg;
    logic [MV_W-1:0]   w_mv;
    logic [OHMS_W-1:0] w_ohms;
    logic              w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count   <= RST_SAMPLE_COUNT;
            r_cfg.pull_up_mode   <= RST_PULL_UP;
            r_cfg.ref_millivolts <= RST_REF_MV;
            r_cfg.known_ohms     <= RST_KNOWN_OHMS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_COUNT: r_cfg.sample_count   <= i_cfg_wdata[CNT_W-1:0];
                CFG_PULL_UP:      r_cfg.pull_up_mode   <= i_cfg_wdata[0];
                CFG_REF_MV:       r_cfg.ref_millivolts <= i_cfg_wdata[MV_W-1:0];
                CFG_KNOWN_OHMS:   r_cfg.known_ohms     <= i_cfg_wdata[R_W-1:0];
                default: begin
                end
            endcase
        end
    end

    adr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    adr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_average_q6 (w_avg),
        .o_millivolts (w_mv),
        .o_ohms       (w_ohms),
        .o_saturated  (w_sat)
    );

    assign m_axis_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, w_ohms, w_mv, w_avg};
    assign m_axis_tuser = w_sat;

    `ADR_ASSERT_IMP(a_sat_all_ones, m_axis_tvalid && w_sat, w_ohms == '1, "ohms not all ones")
    `ADR_ASSERT_IMP(a_avg_range, m_axis_tvalid, w_avg <= AVG_MAX, "average above full scale")
    `ADR_ASSERT_IMP(a_busy_not_ready, w_cmd.mul || w_cmd.div_step, !s_axis_tready, "tready high")
    `ADR_ASSERT_IMP(a_load_when_free, w_cmd.out_load, w_sts.out_free, "output register busy")
    `ADR_ASSERT_NEXT(a_load_valid, w_cmd.out_load, m_axis_tvalid, "loaded result not presented")

endmodule

/* dv/averaged_divider_resistance_tb.sv */
typedef struct {
    logic [adr_pkg::AVG_W-1:0]  average_q6;
    logic [adr_pkg::MV_W-1:0]   millivolts;
    logic [adr_pkg::OHMS_W-1:0] ohms;
    logic                       saturated;
} t_meter_reading;

class window_checker;
    logic [adr_pkg::CNT_W-1:0] sample_count;
    logic                      pull_up;
    logic [adr_pkg::MV_W-1:0]  ref_mv;
    logic [adr_pkg::R_W-1:0]   known_ohms;
    logic [adr_pkg::SUM_W-1:0] window_sum;
    logic [adr_pkg::CNT_W-1:0] window_len;
    t_meter_reading            readings_due[$];
    int unsigned               errors;

    function new();
        sample_count = adr_pkg::RST_SAMPLE_COUNT;
        pull_up      = adr_pkg::RST_PULL_UP;
        ref_mv       = adr_pkg::RST_REF_MV;
        known_ohms   = adr_pkg::RST_KNOWN_OHMS;
        window_sum   = '0;
        window_len   = '0;
        errors       = 0;
    endfunction

    function void write_reg(adr_pkg::t_cfg_idx idx, logic [adr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            adr_pkg::CFG_SAMPLE_COUNT: sample_count = data[adr_pkg::CNT_W-1:0];
            adr_pkg::CFG_PULL_UP:      pull_up = data[0];
            adr_pkg::CFG_REF_MV:       ref_mv = data[adr_pkg::MV_W-1:0];
            adr_pkg::CFG_KNOWN_OHMS:   known_ohms = data[adr_pkg::R_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return readings_due.size();
    endfunction

    function void add_sample(logic [adr_pkg::S_TDATA_W-1:0] data);
        logic [adr_pkg::CNT_W-1:0] limit;
        logic [63:0] n, full, num, den, quot;
        t_meter_reading r;
        limit = (sample_count == 0) ? adr_pkg::CNT_W'(1) : sample_count;
        window_sum = window_sum
            + adr_pkg::SUM_W'(data[adr_pkg::SAMPLE_W-1:0] & adr_pkg::SAMPLE_MASK);
        window_len = window_len + 1'b1;
        // A window closes once the count reaches or passes the current setting.
        if (window_len != 0 && window_len < limit) return;
        n = (window_len == 0) ? 64'd1024 : 64'(window_len);
        full = 64'(adr_pkg::FULL_CODE) * n;
        if (pull_up) begin
            num = 64'(known_ohms) * (full - 64'(window_sum));
            den = 64'(window_sum);
        end else begin
            num = 64'(known_ohms) * 64'(window_sum);
            den = full - 64'(window_sum);
        end
        r.saturated = 1'b0;
        r.ohms = '1;
        if (den == 0) begin
            r.saturated = 1'b1;
        end else begin
            quot = num / den;
            if (quot > 64'hFFFF_FFFF) r.saturated = 1'b1;
            else r.ohms = quot[adr_pkg::OHMS_W-1:0];
        end
        r.average_q6 = adr_pkg::AVG_W'((64'(window_sum) * 64'(adr_pkg::AVG_SCALE)) / n);
        r.millivolts = adr_pkg::MV_W'((64'(ref_mv) * 64'(window_sum)) / full);
        readings_due.push_back(r);
        window_sum = '0;
        window_len = '0;
    endfunction

    function void check_reading(t_meter_reading got);
        t_meter_reading want;
        if (readings_due.size() == 0) begin
            $error("Unexpected result: average_q6 %0d millivolts %0d ohms %0d saturated %0d",
                   got.average_q6, got.millivolts, got.ohms, got.saturated);
            errors++;
            return;
        end
        want = readings_due.pop_front();
        if (got.average_q6 !== want.average_q6) begin
            $error("average_q6: expected %0d, got %0d", want.average_q6, got.average_q6);
            errors++;
        end
        if (got.millivolts !== want.millivolts) begin
            $error("millivolts: expected %0d, got %0d", want.millivolts, got.millivolts);
            errors++;
        end
        if (got.ohms !== want.ohms) begin
            $error("ohms: expected %0d, got %0d", want.ohms, got.ohms);
            errors++;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module averaged_divider_resistance_tb;
    import adr_pkg::*;

    localparam int IDLE_PCT       = 29;
    localparam int SETTLE_CYCLES  = 150;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int STALL_LIMIT    = 4000;
    localparam int TOTAL_ITEMS    = 950;

    typedef enum {NEAR_ZERO, NEAR_FULL, ANY_CODE} t_sample_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // average_q6, millivolts, ohms
    logic [0:0]            m_axis_tuser;        // saturated
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    bit          gaps_on = 1'b1;
    bit          rx_hold_start = 1'b0;
    bit          rx_hold_done = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;

    window_checker meter = new();

    averaged_divider_resistance i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: random stalls, plus one long hold-off so that results back up.
    always @(posedge i_clk) begin
        if (rx_hold_start && !rx_hold_done) begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_meter_reading got;
        if (i_rst_n) begin
            if (i_cfg_we) meter.write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_wdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.average_q6 = m_axis_tdata[AVG_W-1:0];
                got.millivolts = m_axis_tdata[AVG_W +: MV_W];
                got.ohms       = m_axis_tdata[AVG_W + MV_W +: OHMS_W];
                got.saturated  = m_axis_tuser[0];
                meter.check_reading(got);
            end
            if (s_axis_tvalid && s_axis_tready) meter.add_sample(s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(code);
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Drains every pending result, then lets the block finish any work in flight.
    task automatic wait_settled();
        s_axis_tvalid <= 1'b0;
        while (meter.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CNT_W-1:0] count, input logic pull,
                                 input logic [MV_W-1:0] mv, input logic [R_W-1:0] r);
        logic [CFG_DATA_W-1:0] fill;
        wait_settled();
        // Unused high bits of the write data carry junk now and then.
        fill = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SAMPLE_COUNT;
        i_cfg_wdata <= {fill[CFG_DATA_W-1:CNT_W], count};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PULL_UP;
        i_cfg_wdata <= {fill[CFG_DATA_W-1:1], pull};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_REF_MV;
        i_cfg_wdata <= {fill[CFG_DATA_W-1:MV_W], mv};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_KNOWN_OHMS;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_sample_shape shape);
        case (shape)
            NEAR_ZERO: return SAMPLE_W'($urandom_range(3));
            NEAR_FULL: return SAMPLE_W'($urandom_range(SAMPLE_MASK, SAMPLE_MASK - 3));
            default:   return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_phase();
        logic [CNT_W-1:0] count;
        logic             pull;
        logic [MV_W-1:0]  mv;
        logic [R_W-1:0]   r;
        int unsigned      pick, eff, windows, n_items;
        t_sample_shape    shape;
        pick = $urandom_range(99);
        if (pick < 5) count = '0;
        else if (pick < 35) count = CNT_W'(1);
        else if (pick < 80) count = CNT_W'($urandom_range(8, 2));
        else if (pick < 97) count = CNT_W'($urandom_range(64, 9));
        else count = CNT_W'($urandom_range(200, 65));
        pull = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 10) mv = '0;
        else if (pick < 20) mv = '1;
        else if (pick < 80) mv = MV_W'($urandom_range(5000));
        else mv = MV_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) r = '0;
        else if (pick < 20) r = '1;
        else if (pick < 30) r = R_W'(1);
        else r = R_W'($urandom);
        apply_setting(count, pull, mv, r);
        gaps_on = ($urandom_range(99) < 85);
        eff = (count == 0) ? 1 : count;
        windows = 64 / eff;
        if (windows == 0) windows = 1;
        if (windows > 6) windows = 6;
        n_items = eff * windows;
        // A partial window carries over into the next setting.
        if ($urandom_range(99) < 30) n_items += $urandom_range(eff - 1);
        pick = $urandom_range(99);
        shape = (pick < 15) ? NEAR_ZERO : (pick < 30) ? NEAR_FULL : ANY_CODE;
        repeat (n_items) send_sample(pick_sample(shape));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One window under the reset settings.
        repeat (RST_SAMPLE_COUNT) send_sample(SAMPLE_W'($urandom));

        apply_setting(CNT_W'(1), 1'b0, MV_W'(5000), R_W'(10000));
        send_sample('0);
        send_sample(SAMPLE_MASK);
        send_sample(SAMPLE_W'(512));
        send_sample(SAMPLE_W'(1));

        apply_setting(CNT_W'(1), 1'b1, '1, R_W'(10000));
        send_sample('0);
        send_sample(SAMPLE_MASK);
        send_sample(SAMPLE_W'(1));

        // Zero count, zero reference and zero known resistor together.
        apply_setting('0, 1'b0, '0, '0);
        send_sample(SAMPLE_MASK);
        send_sample(SAMPLE_W'(300));

        // Sum one below full scale with the largest resistor overflows the quotient.
        apply_setting(CNT_W'(8), 1'b0, MV_W'(3300), '1);
        repeat (7) send_sample(SAMPLE_MASK);
        send_sample(SAMPLE_MASK - 1'b1);

        // Lower the count mid-window; the next sample closes a window of five.
        apply_setting(CNT_W'(6), 1'b1, MV_W'(3300), '1);
        send_sample(SAMPLE_W'(1));
        repeat (3) send_sample('0);
        apply_setting(CNT_W'(2), 1'b1, MV_W'(3300), '1);
        send_sample('0);

        // Long window at full scale, with no idling on either side.
        gaps_on = 1'b0;
        apply_setting(CNT_W'(600), 1'b0, MV_W'(5000), R_W'(1));
        repeat (600) send_sample(SAMPLE_MASK);

        gaps_on = 1'b1;
        apply_setting(CNT_W'(1), 1'($urandom_range(1)), MV_W'($urandom_range(5000)),
                      R_W'($urandom));
        rx_hold_start = 1'b1;
        repeat (20) send_sample(SAMPLE_W'($urandom));

        while (items_sent < TOTAL_ITEMS) random_phase();

        wait_settled();
        if (meter.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/adr_pkg.sv
rtl/core/adr_ctrl.sv
rtl/core/adr_dpath.sv
rtl/core/averaged_divider_resistance.sv
dv/averaged_divider_resistance_tb.sv
